// ===== hdl/cdconv_pkg.sv =====
`default_nettype none
package cdconv_pkg;

  // Field widths of the fixed-point datapath
  localparam int CH_W      = 6;
  localparam int TAP_W     = 2;
  localparam int VALUE_W   = 16;
  localparam int PROD_W    = 2 * VALUE_W;
  localparam int FRAC_BITS = 12;
  localparam int ROUND_BIAS = 1 << (FRAC_BITS - 1);

  // Item kinds on the input channel
  localparam logic MODE_WEIGHT = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef struct packed {
    logic                       mode;
    logic [CH_W-1:0]            channel;
    logic [TAP_W-1:0]           tap;
    logic signed [VALUE_W-1:0]  value;
    logic                       warmup;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]            out_channel;
    logic signed [VALUE_W-1:0]  result;
    logic                       saturated;
  } out_item_t;

endpackage
`default_nettype wire

// ===== hdl/causal_depthwise_conv1d.sv =====
`default_nettype none
// Per-channel causal FIR filter. A transaction either loads one weight (channel, tap) or
// delivers one Q4.12 sample; a sample is multiplied with its channel's TAPS weights against
// the channel's last TAPS-1 samples, the sum is rounded and saturated to Q4.12, and the
// sample then shifts into that channel's history. Warmup samples only fill the history.
// Weights and history live in two CHANNELS-deep memories with registered reads, so the
// block takes one transaction per clock while out_ready does not hold it back; a result
// passes the memory read, product and result registers before it appears on out_.
// Back-to-back samples of one channel are forwarded around the history memory. Memories
// are not cleared: weights and history must be written first.
module causal_depthwise_conv1d #(
  parameter int CHANNELS = 64,
  parameter int TAPS     = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cdconv_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cdconv_pkg::out_item_t out_data
);

  localparam int AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TW  = $clog2(TAPS);
  localparam int VW  = cdconv_pkg::VALUE_W;
  localparam int PW  = cdconv_pkg::PROD_W;
  localparam int CW  = cdconv_pkg::CH_W;

  typedef logic [TAPS-1:0][VW-1:0] wword_t;
  typedef logic [TAPS-2:0][VW-1:0] hword_t;

  wword_t wmem [CHANNELS];
  hword_t hmem [CHANNELS];

  // Pipeline control
  logic in_fire, sample_ok, weight_ok;
  logic s1_v_r, s2_v_r, out_valid_r;
  logic s1_go, s1_free, s2_free, adv_out;

  // Stage 1: item plus memory read data
  logic [CW-1:0]        s1_ch_r;
  logic signed [VW-1:0] s1_value_r;
  logic                 s1_emit_r;
  wword_t               w_rd_r;
  hword_t               h_rd_r;
  logic                 fwd_v_r;
  hword_t               fwd_h_r;

  // Stage 2: products
  logic [CW-1:0]        s2_ch_r;
  logic signed [PW-1:0] prod_r   [TAPS];
  logic signed [PW-1:0] prod_nxt [TAPS];

  cdconv_pkg::out_item_t out_data_r;
  cdconv_pkg::out_item_t out_nxt;

  logic [AW+CW-1:0] in_ch_ext, s1_ch_ext;
  logic [AW-1:0]    in_addr, s1_addr;
  logic [TW+cdconv_pkg::TAP_W-1:0] tap_ext;
  logic [TW-1:0]    tap_idx;
  logic             ch_in_range, tap_in_range;

  hword_t               h_cur, h_new;
  logic signed [VW-1:0] op_a [TAPS];
  logic signed [VW-1:0] op_b [TAPS];

  // Map channel and tap fields onto memory address and lane
  assign in_ch_ext    = {AW'(0), in_data.channel};
  assign in_addr      = in_ch_ext[AW-1:0];
  assign s1_ch_ext    = {AW'(0), s1_ch_r};
  assign s1_addr      = s1_ch_ext[AW-1:0];
  assign tap_ext      = {TW'(0), in_data.tap};
  assign tap_idx      = tap_ext[TW-1:0];
  assign ch_in_range  = (32'(in_data.channel) < CHANNELS);
  assign tap_in_range = (32'(in_data.tap) < TAPS);

  // Advance each stage when the one after it is free
  assign adv_out  = !out_valid_r || out_ready;
  assign s2_free  = !s2_v_r || adv_out;
  assign s1_go    = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_ready = s1_free;
  assign in_fire  = in_valid && in_ready;

  assign sample_ok = in_fire && ch_in_range && (in_data.mode == cdconv_pkg::MODE_SAMPLE);
  assign weight_ok = in_fire && ch_in_range && tap_in_range &&
                     (in_data.mode == cdconv_pkg::MODE_WEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_r <= sample_ok;
      end
      if (s2_free) begin
        s2_v_r <= s1_go && s1_emit_r;
      end
      if (adv_out) begin
        out_valid_r <= s2_v_r;
      end
    end
  end

  // Weight memory: lane write on weight transactions, word read on samples
  always_ff @(posedge clk) begin
    if (weight_ok) begin
      wmem[in_addr][tap_idx] <= in_data.value;
    end
    if (sample_ok) begin
      w_rd_r <= wmem[in_addr];
    end
  end

  // History memory: write back the shifted history as stage 1 leaves, read on samples
  always_ff @(posedge clk) begin
    if (s1_go) begin
      hmem[s1_addr] <= h_new;
    end
    if (sample_ok) begin
      h_rd_r <= hmem[in_addr];
    end
  end

  // Capture the sample and the bypass for a history written in the same cycle
  always_ff @(posedge clk) begin
    if (sample_ok) begin
      s1_ch_r    <= in_data.channel;
      s1_value_r <= in_data.value;
      s1_emit_r  <= !in_data.warmup;
      fwd_v_r    <= s1_go && (s1_addr == in_addr);
      fwd_h_r    <= h_new;
    end
  end

  // Pick current history and shift the new sample in
  always_comb begin
    h_cur = fwd_v_r ? fwd_h_r : h_rd_r;
    for (int i = 0; i < TAPS - 2; i++) begin
      h_new[i] = h_cur[i+1];
    end
    h_new[TAPS-2] = s1_value_r;
  end

  // Multiply each tap in parallel; the newest tap takes the incoming sample
  always_comb begin
    for (int i = 0; i < TAPS - 1; i++) begin
      op_a[i] = h_cur[i];
    end
    op_a[TAPS-1] = s1_value_r;
    for (int i = 0; i < TAPS; i++) begin
      op_b[i]     = w_rd_r[i];
      prod_nxt[i] = PW'(op_a[i]) * PW'(op_b[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_go) begin
      s2_ch_r <= s1_ch_r;
      prod_r  <= prod_nxt;
    end
  end

  // Sum, round and saturate into the result register
  cdconv_acc #(
    .TAPS (TAPS)
  ) u_acc (
    .prod      (prod_r),
    .result    (out_nxt.result),
    .saturated (out_nxt.saturated)
  );

  assign out_nxt.out_channel = s2_ch_r;

  always_ff @(posedge clk) begin
    if (adv_out && s2_v_r) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== hdl/cdconv_acc.sv =====
`default_nettype none
module cdconv_acc #(
  parameter int TAPS = 4
) (
  input  logic signed [cdconv_pkg::PROD_W-1:0]  prod [TAPS],
  output logic signed [cdconv_pkg::VALUE_W-1:0] result,
  output logic                                  saturated
);

  // Sum width with headroom for all taps plus the rounding bias
  localparam int SW = cdconv_pkg::PROD_W + $clog2(TAPS) + 1;
  localparam logic signed [SW-1:0] BIAS  = SW'(cdconv_pkg::ROUND_BIAS);
  localparam logic signed [SW-1:0] Q_MAX = SW'(32'sd32767);
  localparam logic signed [SW-1:0] Q_MIN = SW'(-32'sd32768);

  logic signed [SW-1:0] acc;
  logic signed [SW-1:0] q;

  // Add up the tap products exactly
  always_comb begin
    acc = '0;
    for (int i = 0; i < TAPS; i++) begin
      acc = acc + SW'(prod[i]);
    end
  end

  // Round half up to Q4.12, then clip to 16 bits
  always_comb begin
    q = (acc + BIAS) >>> cdconv_pkg::FRAC_BITS;
    if (q > Q_MAX) begin
      result    = Q_MAX[cdconv_pkg::VALUE_W-1:0];
      saturated = 1'b1;
    end else if (q < Q_MIN) begin
      result    = Q_MIN[cdconv_pkg::VALUE_W-1:0];
      saturated = 1'b1;
    end else begin
      result    = q[cdconv_pkg::VALUE_W-1:0];
      saturated = 1'b0;
    end
  end

endmodule
`default_nettype wire
